[rtl/rmf_pkg.sv]
// Shared types, constants and compare helpers for the RGB 3x3 median filter.
package rmf_pkg;

    localparam int PIXEL_BITS      = 8;
    localparam int RGB_BITS        = 3 * PIXEL_BITS;
    localparam int MAX_WIDTH_DEF   = 1024;

    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 13;
    // row counter runs one past the height while draining
    localparam int ROW_BITS        = HEIGHT_REG_BITS + 1;
    localparam int WIDTH_RESET     = 640;
    localparam int HEIGHT_RESET    = 480;

    localparam int CFG_INDEX_BITS  = 4;
    localparam int CFG_DATA_BITS   = HEIGHT_REG_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef logic [PIXEL_BITS-1:0] t_pix;

    typedef struct packed {
        t_pix red;
        t_pix green;
        t_pix blue;
    } t_rgb;

    // what the raster tracker decides for the beat on the input port
    typedef struct packed {
        logic consume;   // beat enters the pipeline
        logic drain;     // position past the last row: pixel data forced to zero
        logic emit;      // a result leaves for this position
        logic interior;  // result is the median, else the center passes through
        logic last;      // result is the final pixel of the frame
    } t_pos;

    function automatic t_pix pix_min(input t_pix a, input t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_pix pix_max(input t_pix a, input t_pix b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_pix pix_med3(input t_pix a, input t_pix b, input t_pix c);
        return pix_max(pix_min(a, b), pix_min(pix_max(a, b), c));
    endfunction

endpackage

[rtl/rgb_median3x3_filter.sv]
// Top level of the streaming RGB 3x3 median filter.
// A result beat passes the S1, S2 and S3 registers into the output register after the input
//   beat that completes its window, i.e. one row plus one pixel later in raster order; flush
//   beats stand in for the positions after the last pixel. Throughput: one beat per cycle
//   while the skid entry is free, set by the line-buffer RAM (one read, one write per cycle).
// Reset: synchronous, active low; clears positions, pipeline valids and the two-entry output
//   buffer, and sets the geometry to 640 x 480. Line buffers and window keep their contents.
module rgb_median3x3_filter #(
    parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rmf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [rmf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    // pixel input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  rmf_pkg::t_pix                      i_red_in,
    input  rmf_pkg::t_pix                      i_green_in,
    input  rmf_pkg::t_pix                      i_blue_in,
    // pixel output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output rmf_pkg::t_pix                      o_red_out,
    output rmf_pkg::t_pix                      o_green_out,
    output rmf_pkg::t_pix                      o_blue_out,
    output logic                               o_frame_last
);

    import rmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Pipeline, all stages advance together on w_en:
    //   accept : position decisions, line-buffer read issued
    //   S1     : line-buffer data back, write-back of the shifted column
    //   S2     : column sorted and shifted into each lane's window
    //   S3     : per-lane partial medians registered
    //   out    : lanes merged into the output register (plus one skid entry)
    // The pipeline only stops when the skid entry is occupied, so a beat can
    // be accepted while a finished result waits in the output register.

    logic          w_en;
    logic          w_take;
    logic          w_cfg_we;
    t_pos          w_pos;
    logic [CW-1:0] w_col;
    t_rgb          w_pix_in;

    // line buffer word: {upper row, middle row}
    logic [2*RGB_BITS-1:0] w_rdata;
    t_rgb                  w_rd_upper, w_rd_middle;
    t_rgb                  w_s1_top, w_s1_mid;
    logic                  w_ram_we;
    logic                  w_hazard;

    // S1
    logic          r_s1_valid;
    logic [CW-1:0] r_s1_col;
    t_rgb          r_s1_pix;
    logic          r_s1_emit, r_s1_interior, r_s1_last;
    logic          r_s1_fwd;
    t_rgb          r_fwd_upper, r_fwd_middle;

    // S2 / S3 control
    logic r_s2_emit, r_s2_interior, r_s2_last;
    logic r_s3_emit, r_s3_interior, r_s3_last;

    // lane results and merge
    t_rgb w_med, w_ctr, w_res;
    logic w_new;
    logic w_taken;

    // output register and skid entry
    logic r_o_valid, r_k_valid;
    t_rgb r_o_data, r_k_data;
    logic r_o_last, r_k_last;

    assign w_en        = !r_k_valid;
    assign o_in_stall  = r_k_valid || !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_take      = i_in_valid && !o_in_stall;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    rmf_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_command   (i_command),
        .o_pos       (w_pos),
        .o_col       (w_col)
    );

    // past the last row the drain feeds zeros through the line buffers
    assign w_pix_in = w_pos.drain ? '0 : t_rgb'{red: i_red_in, green: i_green_in,
                                                 blue: i_blue_in};

    // Same column read while S1 writes it back: at width one and after a frame's last beat;
    // the written values are kept and used in place of the stale read.
    assign w_hazard = w_pos.consume && r_s1_valid && (w_col == r_s1_col);
    assign w_ram_we = w_en && r_s1_valid;

    rmf_ram #(
        .WIDTH (2 * RGB_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s1_col),
        .i_wdata ({w_s1_mid, r_s1_pix}),
        .i_re    (w_pos.consume),
        .i_raddr (w_col),
        .o_rdata (w_rdata)
    );

    assign w_rd_upper  = w_rdata[2*RGB_BITS-1:RGB_BITS];
    assign w_rd_middle = w_rdata[RGB_BITS-1:0];
    assign w_s1_top    = r_s1_fwd ? r_fwd_upper  : w_rd_upper;
    assign w_s1_mid    = r_s1_fwd ? r_fwd_middle : w_rd_middle;

    // one lane per color channel
    rmf_lane u_lane_red (
        .i_clk    (i_clk),
        .i_shift  (w_ram_we),
        .i_step   (w_en),
        .i_top    (w_s1_top.red),
        .i_mid    (w_s1_mid.red),
        .i_pix    (r_s1_pix.red),
        .o_median (w_med.red),
        .o_center (w_ctr.red)
    );

    rmf_lane u_lane_green (
        .i_clk    (i_clk),
        .i_shift  (w_ram_we),
        .i_step   (w_en),
        .i_top    (w_s1_top.green),
        .i_mid    (w_s1_mid.green),
        .i_pix    (r_s1_pix.green),
        .o_median (w_med.green),
        .o_center (w_ctr.green)
    );

    rmf_lane u_lane_blue (
        .i_clk    (i_clk),
        .i_shift  (w_ram_we),
        .i_step   (w_en),
        .i_top    (w_s1_top.blue),
        .i_mid    (w_s1_mid.blue),
        .i_pix    (r_s1_pix.blue),
        .o_median (w_med.blue),
        .o_center (w_ctr.blue)
    );

    // merge: border pixels pass the window center through
    assign w_res   = r_s3_interior ? w_med : w_ctr;
    assign w_new   = w_en && r_s3_emit;
    assign w_taken = r_o_valid && !i_out_stall;

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_emit  <= 1'b0;
            r_s3_emit  <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_pos.consume;
            r_s2_emit  <= r_s1_valid && r_s1_emit;
            r_s3_emit  <= r_s2_emit;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_pos.consume) begin
                r_s1_col      <= w_col;
                r_s1_pix      <= w_pix_in;
                r_s1_emit     <= w_pos.emit;
                r_s1_interior <= w_pos.interior;
                r_s1_last     <= w_pos.last;
                r_s1_fwd      <= w_hazard;
            end
            if (w_hazard) begin
                r_fwd_upper  <= w_s1_mid;
                r_fwd_middle <= r_s1_pix;
            end
            r_s2_interior <= r_s1_interior;
            r_s2_last     <= r_s1_last;
            r_s3_interior <= r_s2_interior;
            r_s3_last     <= r_s2_last;
        end
    end

    // output register + skid entry control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_k_valid <= 1'b0;
        end else if (w_taken) begin
            if (r_k_valid) begin
                r_k_valid <= 1'b0;
            end else begin
                r_o_valid <= w_new;
            end
        end else if (!r_o_valid) begin
            r_o_valid <= w_new;
        end else if (w_new) begin
            r_k_valid <= 1'b1;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_taken && r_k_valid) begin
            r_o_data <= r_k_data;
            r_o_last <= r_k_last;
        end else if (w_new && (w_taken || !r_o_valid)) begin
            r_o_data <= w_res;
            r_o_last <= r_s3_last;
        end
        if (w_new && r_o_valid && !w_taken) begin
            r_k_data <= w_res;
            r_k_last <= r_s3_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_red_out    = r_o_data.red;
    assign o_green_out  = r_o_data.green;
    assign o_blue_out   = r_o_data.blue;
    assign o_frame_last = r_o_last;

endmodule

[rtl/rmf_ram.sv]
// Generic simple dual-port RAM with registered read.
module rmf_ram #(
    parameter int WIDTH = rmf_pkg::RGB_BITS,
    parameter int DEPTH = rmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rmf_pos.sv]
// Raster position tracker and frame geometry registers.
module rmf_pos #(
    parameter int MAX_WIDTH = rmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rmf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [rmf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_take,
    input  logic                                i_command,
    output rmf_pkg::t_pos                       o_pos,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col
);

    import rmf_pkg::*;

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int EW         = (WW > WIDTH_REG_BITS) ? WW : WIDTH_REG_BITS;
    localparam int WIDTH_INIT = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [WW-1:0]              r_width;
    logic [HEIGHT_REG_BITS-1:0] r_height;
    logic [CW-1:0]              r_col;
    logic [ROW_BITS-1:0]        r_row;

    logic [WW-1:0]              n_width;
    logic [HEIGHT_REG_BITS-1:0] n_height;
    logic [CW-1:0]              n_col;
    logic [ROW_BITS-1:0]        n_row;

    logic [EW-1:0]              w_wval;
    logic [HEIGHT_REG_BITS-1:0] w_hval;
    logic [ROW_BITS-1:0]        w_h;
    logic [WW-1:0]              w_col_inc;
    logic                       w_drain;

    // clamp written geometry to the supported range
    always_comb begin
        w_wval = EW'(i_cfg_data[WIDTH_REG_BITS-1:0]);
        if (w_wval == '0) begin
            n_width = WW'(1);
        end else if (w_wval > EW'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = w_wval[WW-1:0];
        end
        w_hval   = i_cfg_data[HEIGHT_REG_BITS-1:0];
        n_height = (w_hval == '0) ? HEIGHT_REG_BITS'(1) : w_hval;
    end

    always_comb begin
        w_h       = ROW_BITS'(r_height);
        w_col_inc = WW'(r_col) + WW'(1);
        w_drain   = (r_row >= w_h);

        o_pos.consume  = i_take && !(!w_drain && (i_command == CMD_FLUSH));
        o_pos.drain    = w_drain;
        o_pos.emit     = (r_row >= ROW_BITS'(2)) ||
                         ((r_row == ROW_BITS'(1)) && (r_col != '0));
        o_pos.interior = (r_col >= CW'(2)) && (r_row >= ROW_BITS'(2)) && (r_row != w_h);
        o_pos.last     = (r_col == '0) && (r_row == w_h + ROW_BITS'(1));

        if (o_pos.last) begin
            n_col = '0;
            n_row = '0;
        end else if (w_col_inc == r_width) begin
            n_col = '0;
            n_row = r_row + ROW_BITS'(1);
        end else begin
            n_col = w_col_inc[CW-1:0];
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WW'(WIDTH_INIT);
            r_height <= HEIGHT_REG_BITS'(HEIGHT_RESET);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WIDTH: begin
                    r_width <= n_width;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                REG_HEIGHT: begin
                    r_height <= n_height;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: ;
            endcase
        end else if (o_pos.consume) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;

endmodule

[rtl/rmf_lane.sv]
// One color lane: column sort, sorted 3x3 window and median network.
module rmf_lane (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_step,
    input  rmf_pkg::t_pix i_top,
    input  rmf_pkg::t_pix i_mid,
    input  rmf_pkg::t_pix i_pix,
    output rmf_pkg::t_pix o_median,
    output rmf_pkg::t_pix o_center
);

    import rmf_pkg::*;

    t_pix w_lo1, w_hi1, w_t;
    t_pix n_lo, n_md, n_hi;
    t_pix r_lo [3];
    t_pix r_md [3];
    t_pix r_hi [3];
    t_pix r_raw1, r_raw2;
    t_pix n_a, n_b, n_c;
    t_pix r_a, r_b, r_c, r_center;

    // sort the incoming column once; the window keeps columns sorted
    always_comb begin
        w_lo1 = pix_min(i_top, i_mid);
        w_hi1 = pix_max(i_top, i_mid);
        w_t   = pix_max(w_lo1, i_pix);
        n_lo  = pix_min(w_lo1, i_pix);
        n_md  = pix_min(w_hi1, w_t);
        n_hi  = pix_max(w_hi1, w_t);
    end

    // median of nine = med3(max of lows, med of mids, min of highs)
    always_comb begin
        n_a = pix_max(pix_max(r_lo[0], r_lo[1]), r_lo[2]);
        n_b = pix_med3(r_md[0], r_md[1], r_md[2]);
        n_c = pix_min(pix_min(r_hi[0], r_hi[1]), r_hi[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_lo[0] <= r_lo[1];
            r_lo[1] <= r_lo[2];
            r_lo[2] <= n_lo;
            r_md[0] <= r_md[1];
            r_md[1] <= r_md[2];
            r_md[2] <= n_md;
            r_hi[0] <= r_hi[1];
            r_hi[1] <= r_hi[2];
            r_hi[2] <= n_hi;
            r_raw1  <= r_raw2;
            r_raw2  <= i_mid;
        end
        if (i_step) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_c      <= n_c;
            r_center <= r_raw1;
        end
    end

    assign o_median = pix_med3(r_a, r_b, r_c);
    assign o_center = r_center;

endmodule

[rtl/rmf_checker.sv]
// Port-level checker for the RGB 3x3 median filter, bound to the top level.
module rmf_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input rmf_pkg::t_pix o_red_out,
    input rmf_pkg::t_pix o_green_out,
    input rmf_pkg::t_pix o_blue_out,
    input logic          o_frame_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red_out) &&
        $stable(o_green_out) && $stable(o_blue_out) && $stable(o_frame_last))
        else $error("result beat changed while stalled");

    // input back-pressure only with a result waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // back-pressure starts only after a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall rose without output stall");

    // back-pressure persists while the output stays stalled
    a_stall_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && i_out_stall |=> o_in_stall)
        else $error("input stall dropped while output still stalled");

endmodule

bind rgb_median3x3_filter rmf_checker u_rmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_red_out    (o_red_out),
    .o_green_out  (o_green_out),
    .o_blue_out   (o_blue_out),
    .o_frame_last (o_frame_last)
);

[test/testbench.sv]
// Self-checking testbench for the RGB 3x3 median filter: frame geometries, drain and restarts.
`timescale 1ns / 100ps
module testbench;
    import rmf_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int SETTLE_CYC   = 8;      // output pipeline depth plus margin
    localparam int TAIL_CYC     = 20;     // quiet time at the end to catch stray beats
    localparam int WIDE_DRAIN   = 8;      // drain ticks on each side of the pause in the wide row
    localparam int RANDOM_BEATS = 80;     // random section; the wide row takes most of the run
    localparam int CYCLE_LIMIT  = 500000;

    // index past the register list, every bit set; the block must ignore it
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = '1;

    typedef struct {
        bit   hold;      // pause marker: sender waits until every result is back
        logic command;
        t_rgb px;
    } t_stim_beat;

    typedef struct {
        t_rgb px;
        logic last;
    } t_out_pixel;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic                      i_command   = CMD_PIXEL;
    t_pix                      i_red_in    = '0;
    t_pix                      i_green_in  = '0;
    t_pix                      i_blue_in   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_pix                      o_red_out;
    t_pix                      o_green_out;
    t_pix                      o_blue_out;
    logic                      o_frame_last;

    rgb_median3x3_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Filter state as the testbench tracks it
    // ---------------------------------------------------------------
    logic [WIDTH_REG_BITS-1:0]  width_reg  = WIDTH_REG_BITS'(WIDTH_RESET);
    logic [HEIGHT_REG_BITS-1:0] height_reg = HEIGHT_REG_BITS'(HEIGHT_RESET);
    t_rgb row_above [MAX_W];    // per column: pixel two rows back
    t_rgb row_prev  [MAX_W];    // per column: pixel one row back
    t_rgb win [3][3];           // [row][column], column 2 is the newest
    int   next_col = 0;         // raster position of the next beat
    int   next_row = 0;         // runs past the height while draining

    t_out_pixel filtered_q [$]; // filtered pixels still owed by the block
    t_stim_beat stim_q [$];     // beats waiting for the input driver

    int beats_queued  = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int frames_seen   = 0;
    int cfg_writes    = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    // median of the nine window values of one channel (0 red, 1 green, 2 blue)
    function automatic t_pix window_median(input int ch);
        t_pix v [9];
        t_pix t;
        int   k;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                case (ch)
                    0:       v[3*a+b] = win[a][b].red;
                    1:       v[3*a+b] = win[a][b].green;
                    default: v[3*a+b] = win[a][b].blue;
                endcase
            end
        end
        for (int i = 1; i < 9; i++) begin
            t = v[i];
            k = i;
            while (k > 0 && v[k-1] > t) begin
                v[k] = v[k-1];
                k--;
            end
            v[k] = t;
        end
        return v[4];
    endfunction

    // Advance the raster for one accepted input beat; queue the pixel it releases, if any.
    task automatic filter_track_beat(input logic cmd, input t_rgb px_in);
        int         w, h, r, c, orow, ocol;
        t_rgb       top, mid, center, px;
        bit         interior, last;
        t_out_pixel res;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : int'(width_reg));
        h = (height_reg == 0) ? 1 : int'(height_reg);
        r = next_row;
        c = (next_col >= w) ? 0 : next_col;
        px = '0;
        if (r < h) begin
            // flush while pixels are still owed: no effect at all
            if (cmd == CMD_FLUSH)
                return;
            px = px_in;
        end
        // past the last row any beat is a drain tick with zero data

        top    = row_above[c];
        mid    = row_prev[c];
        center = win[1][2];
        row_above[c] = mid;
        row_prev[c]  = px;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = px;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        next_col = c;
        next_row = r;

        // step back to the position just consumed
        if (c == 0) begin
            r--;
            c = w;
        end
        c--;
        // still inside the initial lag of one row plus one pixel
        if (!(r >= 2 || (r == 1 && c >= 1)))
            return;

        if (c >= 1) begin
            orow = r - 1;
            ocol = c - 1;
        end else begin
            orow = r - 2;
            ocol = w - 1;
        end
        interior = orow != 0 && orow != h - 1 && ocol != 0 && ocol != w - 1;
        last     = orow == h - 1 && ocol == w - 1;

        if (interior) begin
            res.px.red   = window_median(0);
            res.px.green = window_median(1);
            res.px.blue  = window_median(2);
        end else begin
            res.px = center;
        end
        res.last = last;
        filtered_q.push_back(res);

        // frame done, next pixel opens a new one
        if (last) begin
            next_col = 0;
            next_row = 0;
        end
    endtask

    // register writes land here; any valid index restarts the frame, line stores stay
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            cfg_writes++;
            if (i_cfg_index == REG_WIDTH) begin
                width_reg = i_cfg_data[WIDTH_REG_BITS-1:0];
                next_col  = 0;
                next_row  = 0;
            end else if (i_cfg_index == REG_HEIGHT) begin
                height_reg = i_cfg_data[HEIGHT_REG_BITS-1:0];
                next_col   = 0;
                next_row   = 0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Input driver: bursts of beats with random gaps, hold markers pause it
    // ---------------------------------------------------------------
    t_stim_beat nxt;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                filter_track_beat(i_command, {i_red_in, i_green_in, i_blue_in});
                beats_taken++;
            end
            // a stalled beat stays put; otherwise pick what goes out next
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (stim_q.size() != 0 && stim_q[0].hold) begin
                    i_in_valid <= 1'b0;
                    if (filtered_q.size() == 0)
                        void'(stim_q.pop_front());
                end else if (stim_q.size() != 0) begin
                    nxt = stim_q.pop_front();
                    i_command  <= nxt.command;
                    i_red_in   <= nxt.px.red;
                    i_green_in <= nxt.px.green;
                    i_blue_in  <= nxt.px.blue;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output monitor and receiver stall pattern
    // ---------------------------------------------------------------
    t_out_pixel  want;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_run  = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected result beat: red_out=%0d green_out=%0d blue_out=%0d",
                           o_red_out, o_green_out, o_blue_out);
                    err_count++;
                end else begin
                    want = filtered_q.pop_front();
                    results_seen++;
                    if (o_red_out !== want.px.red) begin
                        $error("red_out: expected %0d, got %0d", want.px.red, o_red_out);
                        err_count++;
                    end
                    if (o_green_out !== want.px.green) begin
                        $error("green_out: expected %0d, got %0d", want.px.green, o_green_out);
                        err_count++;
                    end
                    if (o_blue_out !== want.px.blue) begin
                        $error("blue_out: expected %0d, got %0d", want.px.blue, o_blue_out);
                        err_count++;
                    end
                    if (o_frame_last !== want.last) begin
                        $error("frame_last: expected %0b, got %0b", want.last, o_frame_last);
                        err_count++;
                    end
                    if (want.last)
                        frames_seen++;
                end
            end

            // stall behavior switches to a new random mode when its random run has counted out
            if (stall_run == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_run  = $urandom_range(20, 300);
            end else begin
                stall_run--;
            end
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
                default:     i_out_stall <= (stall_run % 5) < 2;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, filtered_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_beat(input logic cmd, input t_rgb px);
        t_stim_beat b;
        b.hold    = 1'b0;
        b.command = cmd;
        b.px      = px;
        stim_q.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_hold();
        t_stim_beat b;
        b.hold    = 1'b1;
        b.command = CMD_FLUSH;
        b.px      = '0;
        stim_q.push_back(b);
    endtask

    // mostly full-range channels, some squeezed into a few values to force ties
    function automatic t_rgb rand_pixel();
        t_rgb p;
        p = t_rgb'($urandom);
        if ($urandom_range(0, 3) == 0)
            p.red = t_pix'(126 + $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            p.green = t_pix'(126 + $urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            p.blue = t_pix'(126 + $urandom_range(0, 3));
        return p;
    endfunction

    // called at a clock edge; returns at a clock edge with nothing pending on the channel
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // every queued beat taken, every owed pixel back, then let the pipeline empty
    task automatic settle_pipeline();
        do @(posedge i_clk); while (beats_taken != beats_queued || filtered_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    t_pix tap_red [9] = '{8'd9, 8'd200, 8'd45, 8'd255, 8'd0, 8'd130, 8'd77, 8'd18, 8'd161};
    int   rand_base, w_raw, h_raw, w_eff, h_eff, cut;

    initial begin
        for (int i = 0; i < MAX_W; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                win[a][b] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 frame: one interior pixel whose median differs from its center
        write_reg(REG_WIDTH, CFG_DATA_BITS'(3));
        write_reg(REG_HEIGHT, CFG_DATA_BITS'(3));
        queue_beat(CMD_FLUSH, '0);                    // flush before any pixel: ignored
        for (int i = 0; i < 4; i++)
            queue_beat(CMD_PIXEL, {tap_red[i], ~tap_red[i], 8'hA5});
        settle_pipeline();
        write_reg(REG_UNUSED, '1);                    // out-of-range index: frame goes on
        for (int i = 4; i < 8; i++)
            queue_beat(CMD_PIXEL, {tap_red[i], ~tap_red[i], (i == 4) ? 8'h5A : 8'hA5});
        queue_beat(CMD_FLUSH, '0);                    // still mid-frame: ignored
        queue_beat(CMD_PIXEL, {tap_red[8], ~tap_red[8], 8'hA5});
        queue_beat(CMD_PIXEL, rand_pixel());          // pixel while draining, data dropped
        repeat (3) queue_beat(CMD_FLUSH, '0);
        settle_pipeline();

        // zero registers clamp to a 1x1 frame; first drain tick is inside the lag
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '0);
        queue_beat(CMD_PIXEL, {8'hFF, 8'h00, 8'hFF});
        repeat (2) queue_beat(CMD_FLUSH, '0);
        settle_pipeline();

        // tallest frame, abandoned after two rows and two pixels by a register write
        write_reg(REG_WIDTH, CFG_DATA_BITS'(5));
        write_reg(REG_HEIGHT, '1);
        repeat (12) queue_beat(CMD_PIXEL, rand_pixel());
        settle_pipeline();

        // all-ones width clamps to the widest row; one row, the start of its drain with
        // a pause midway, then abandoned by the next register write
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, CFG_DATA_BITS'(1));
        repeat (MAX_W) queue_beat(CMD_PIXEL, rand_pixel());
        repeat (WIDE_DRAIN) queue_beat(CMD_FLUSH, '0);
        queue_hold();
        repeat (WIDE_DRAIN) queue_beat(CMD_FLUSH, '0);
        settle_pipeline();

        // random frames: mostly complete and drained, some cut short, some noise
        rand_base = beats_queued;
        w_eff = 1;
        h_eff = 1;
        while (beats_queued - rand_base < RANDOM_BEATS) begin
            if (beats_queued == rand_base || $urandom_range(0, 2) == 0) begin
                settle_pipeline();
                if ($urandom_range(0, 4) == 0) begin
                    w_raw = $urandom_range(13, 64);
                    h_raw = $urandom_range(1, 3);
                end else begin
                    w_raw = $urandom_range(0, 12);
                    h_raw = $urandom_range(0, 8);
                end
                write_reg(REG_WIDTH, CFG_DATA_BITS'(w_raw));
                write_reg(REG_HEIGHT, CFG_DATA_BITS'(h_raw));
                w_eff = (w_raw == 0) ? 1 : w_raw;
                h_eff = (h_raw == 0) ? 1 : h_raw;
            end

            cut = w_eff * h_eff;
            if ($urandom_range(0, 14) == 0)
                cut = $urandom_range(0, w_eff * h_eff - 1);
            for (int p = 0; p < cut; p++) begin
                if ($urandom_range(0, 39) == 0)
                    queue_beat(CMD_FLUSH, rand_pixel());
                if ($urandom_range(0, 149) == 0)
                    queue_hold();
                queue_beat(CMD_PIXEL, rand_pixel());
            end

            if (cut < w_eff * h_eff) begin
                // broken frame: rewrite the height to restart mid-frame
                settle_pipeline();
                write_reg(REG_HEIGHT, CFG_DATA_BITS'(h_raw));
            end else begin
                for (int d = 0; d <= w_eff; d++) begin
                    if ($urandom_range(0, 7) == 0)
                        queue_beat(CMD_PIXEL, rand_pixel());
                    else
                        queue_beat(CMD_FLUSH, rand_pixel());
                end
            end
        end

        settle_pipeline();
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("checked %0d result beats in %0d complete frames from %0d input beats",
                 results_seen, frames_seen, beats_taken);
        $display("%0d register writes, geometries from 1x1 up to %0d wide and 8191 tall",
                 cfg_writes, MAX_W);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[rgb_median3x3_filter.f]
rtl/rmf_pkg.sv
rtl/rmf_ram.sv
rtl/rmf_pos.sv
rtl/rmf_lane.sv
rtl/rgb_median3x3_filter.sv
rtl/rmf_checker.sv
test/testbench.sv
